FILE: rtl/core/ndr_pkg.sv
package ndr_pkg;

   // field bytes kept per length or delta field
   localparam int MAX_FIELD_BYTES = 8;

   // command queue between the byte parser and the run builder
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // result item kinds
   typedef enum logic [2:0] {
      KIND_RUN       = 3'd0,
      KIND_ZERO_HDR  = 3'd1,
      KIND_ZERO_WID  = 3'd2,
      KIND_NEGATIVE  = 3'd3,
      KIND_BUF_END   = 3'd4,
      KIND_TRUNCATED = 3'd5
   } kind_type;

   // command opcodes from the parser
   typedef enum logic [1:0] {
      OP_PAIR,
      OP_END,
      OP_RESTART
   } op_type;

   // one parsed command
   typedef struct packed {
      op_type      op;
      kind_type    kind;
      logic        last;
      logic [63:0] delta;
      logic [63:0] length;
   } cmd_type;

endpackage

FILE: rtl/core/ndr_front.sv
module ndr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             queue_full,
   output logic             push,
   output ndr_pkg::cmd_type push_cmd
);
   import ndr_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_DELTA,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  lw_ff, lw_in;
   logic [3:0]  dw_ff, dw_in;
   logic [3:0]  idx_ff, idx_in;
   logic [63:0] lacc_ff, lacc_in;
   logic [63:0] dacc_ff, dacc_in;

   logic        accept;
   logic [3:0]  idx_inc;
   logic [63:0] dacc_new;

   // drop a byte into its lane of the little-endian field
   function automatic logic [63:0] place_byte(input logic [63:0] acc, input logic [7:0] b,
                                              input logic [3:0] idx);
      logic [63:0] r;
      r = acc;
      for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
         if (idx == 4'(k)) begin
            r[8*k +: 8] = r[8*k +: 8] | b;
         end
      end
      return r;
   endfunction

   // sign extend the delta from its top kept byte
   function automatic logic [63:0] sign_extend(input logic [63:0] d, input logic [3:0] dw);
      logic [3:0]  eff;
      logic [63:0] r;
      eff = (dw > 4'(MAX_FIELD_BYTES)) ? 4'(MAX_FIELD_BYTES) : dw;
      r   = d;
      for (int k = 1; k < 8; k++) begin
         if (eff == 4'(k) && d[8*k-1]) begin
            r = r | ({64{1'b1}} << (8*k));
         end
      end
      return r;
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign idx_inc    = idx_ff + 4'd1;
   assign dacc_new   = place_byte(dacc_ff, req_tdata, idx_ff);

   // byte classification and field accumulation
   always_comb begin
      phase_in        = phase_ff;
      lw_in           = lw_ff;
      dw_in           = dw_ff;
      idx_in          = idx_ff;
      lacc_in         = lacc_ff;
      dacc_in         = dacc_ff;
      push            = 1'b0;
      push_cmd.op     = OP_END;
      push_cmd.kind   = KIND_TRUNCATED;
      push_cmd.last   = req_tlast;
      push_cmd.delta  = '0;
      push_cmd.length = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (req_tdata == 8'h00) begin
                  push          = 1'b1;
                  push_cmd.kind = KIND_ZERO_HDR;
                  phase_in      = PH_DONE;
               end else if (req_tdata[3:0] == 4'h0 || req_tdata[7:4] == 4'h0) begin
                  push          = 1'b1;
                  push_cmd.kind = KIND_ZERO_WID;
                  phase_in      = PH_DONE;
               end else begin
                  lw_in    = req_tdata[3:0];
                  dw_in    = req_tdata[7:4];
                  idx_in   = '0;
                  lacc_in  = '0;
                  dacc_in  = '0;
                  phase_in = PH_LENGTH;
                  push     = req_tlast;
               end
            end
            PH_LENGTH: begin
               lacc_in = place_byte(lacc_ff, req_tdata, idx_ff);
               idx_in  = idx_inc;
               if (idx_inc >= lw_ff) begin
                  idx_in   = '0;
                  phase_in = PH_DELTA;
               end
               push = req_tlast;
            end
            PH_DELTA: begin
               dacc_in = dacc_new;
               idx_in  = idx_inc;
               if (idx_inc >= dw_ff) begin
                  push            = 1'b1;
                  push_cmd.op     = OP_PAIR;
                  push_cmd.kind   = KIND_RUN;
                  push_cmd.delta  = sign_extend(dacc_new, dw_ff);
                  push_cmd.length = lacc_ff;
                  idx_in          = '0;
                  phase_in        = PH_HEADER;
               end else begin
                  push = req_tlast;
               end
            end
            PH_DONE: begin
               push = 1'b0;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
         // buffer end restarts the parser and the running cluster
         if (req_tlast) begin
            if (!push) begin
               push        = 1'b1;
               push_cmd.op = OP_RESTART;
            end
            phase_in = PH_HEADER;
            lw_in    = '0;
            dw_in    = '0;
            idx_in   = '0;
            lacc_in  = '0;
            dacc_in  = '0;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         lw_ff    <= '0;
         dw_ff    <= '0;
         idx_ff   <= '0;
         lacc_ff  <= '0;
         dacc_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         lw_ff    <= lw_in;
         dw_ff    <= dw_in;
         idx_ff   <= idx_in;
         lacc_ff  <= lacc_in;
         dacc_ff  <= dacc_in;
      end
   end

endmodule

FILE: rtl/core/ndr_queue.sv
module ndr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ndr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ndr_pkg::cmd_type head_cmd
);
   import ndr_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QUEUE_AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QUEUE_AW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (QUEUE_AW+1)'(1);
         2'b01:   count_in = count_ff - (QUEUE_AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/ndr_back.sv
module ndr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ndr_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [127:0]     rsp_tdata,
   output logic [2:0]       rsp_tuser
);
   import ndr_pkg::*;

   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [62:0] start_ff, start_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] running_ff, running_in;
   logic        drop_ff, drop_in;
   logic        pend_end_ff, pend_end_in;

   logic        slot_free;
   logic [63:0] sum;

   assign slot_free = !valid_ff || rsp_tready;
   assign pop       = slot_free && !pend_end_ff && head_valid;
   assign sum       = running_ff + head_cmd.delta;

   // run building and end handling
   always_comb begin
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      running_in  = running_ff;
      drop_in     = drop_ff;
      pend_end_in = pend_end_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (slot_free && pend_end_ff) begin
         // buffer end right after the final run
         valid_in    = 1'b1;
         kind_in     = KIND_BUF_END;
         start_in    = '0;
         count_in    = '0;
         pend_end_in = 1'b0;
      end else if (pop) begin
         if (drop_ff) begin
            // list ended on a negative cluster: swallow until buffer end
            if (head_cmd.last) begin
               drop_in    = 1'b0;
               running_in = '0;
            end
         end else begin
            unique case (head_cmd.op)
               OP_PAIR: begin
                  valid_in = 1'b1;
                  start_in = '0;
                  count_in = '0;
                  if (sum[63]) begin
                     kind_in    = KIND_NEGATIVE;
                     running_in = head_cmd.last ? '0 : sum;
                     drop_in    = !head_cmd.last;
                  end else begin
                     kind_in     = KIND_RUN;
                     start_in    = sum[62:0];
                     count_in    = head_cmd.length;
                     running_in  = head_cmd.last ? '0 : sum;
                     pend_end_in = head_cmd.last;
                  end
               end
               OP_END: begin
                  valid_in = 1'b1;
                  kind_in  = head_cmd.kind;
                  start_in = '0;
                  count_in = '0;
                  if (head_cmd.last) begin
                     running_in = '0;
                  end
               end
               OP_RESTART: begin
                  running_in = '0;
               end
               default: begin
                  running_in = '0;
               end
            endcase
         end
      end
   end

   // control state and running cluster
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         running_ff  <= '0;
         drop_ff     <= 1'b0;
         pend_end_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         running_ff  <= running_in;
         drop_ff     <= drop_in;
         pend_end_ff <= pend_end_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      start_ff <= start_in;
      count_ff <= count_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {1'b0, count_ff, start_ff};

endmodule

FILE: rtl/core/ntfs_data_run_decoder_top.sv
// the command for a result is stored in the command queue, then the result is registered
// throughput: one byte per cycle while the queue is not full; the single result register
// moves one item per cycle when rsp_tready is high, so a pair ending on the buffer's last
// byte yields a run and a buffer end item; a four-entry queue absorbs that and result stalls
// reset: synchronous, active high; clears parser phase, queue and running cluster at once
module ntfs_data_run_decoder_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] pair_byte
   input  logic         req_tlast,   // buffer_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [62:0] run_start_cluster, [126:63] run_cluster_count
   output logic [2:0]   rsp_tuser    // [2:0] item_kind
);
   import ndr_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_in_cmd;
   cmd_type q_head_cmd;

   // byte parser
   ndr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (q_full),
      .push       (q_push),
      .push_cmd   (q_in_cmd)
   );

   // command queue
   ndr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_in_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   // run builder and result register
   ndr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // no command is written into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("command pushed into full queue");

   // the builder only takes a command that is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from empty queue");

   // end items carry an all-zero payload
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != 3'(KIND_RUN)) |-> (rsp_tdata == '0))
      else $error("end item with nonzero payload");

   // a buffer end item follows the run it closes without a gap
   a_buf_end_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser == 3'(KIND_RUN) && q_valid && !q_pop
       && $past(q_pop) && $past(q_head_cmd.last) && $past(q_head_cmd.op) == OP_PAIR)
      |=> (rsp_tvalid && rsp_tuser == 3'(KIND_BUF_END)))
      else $error("buffer end item not presented after final run");

endmodule
